>>> sv/bapg_pkg.sv
// Shared types, constants and palette of the bitmap/attribute pixel generator.
package bapg_pkg;

    // display memory geometry
    localparam int unsigned MEM_DEPTH  = 6912;
    localparam int unsigned ADDR_W     = 13;
    localparam logic [ADDR_W-1:0] MEM_LAST = ADDR_W'(MEM_DEPTH - 1);
    localparam logic [ADDR_W-1:0] ATTR_BASE = 13'h1800;

    // CPU window of the display memory
    localparam logic [2:0] WIN_PAGE = 3'b010;

    localparam logic [7:0] FLASH_PERIOD_RST = 8'd16;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_TICK  = 2'd1,
        OP_PIXEL = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] cpu_address;
        logic [7:0]  write_data;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  color_index;
        logic [31:0] argb_color;
    } t_out_item;

    // pixel request in flight between address issue and shading
    typedef struct packed {
        logic       valid;
        logic [2:0] bit_pos;
        logic       pix_ok;
        logic       attr_ok;
        logic       phase;
    } t_pix_ctl;

    localparam logic [31:0] PALETTE [16] = '{
        32'hFF000000, 32'hFF0000D7, 32'hFFD70000, 32'hFFD700D7,
        32'hFF00D700, 32'hFF00D7D7, 32'hFFD7D700, 32'hFFD7D7D7,
        32'hFF000000, 32'hFF0000FF, 32'hFFFF0000, 32'hFFFF00FF,
        32'hFF00FF00, 32'hFF00FFFF, 32'hFFFFFF00, 32'hFFFFFFFF
    };

endpackage

>>> sv/bapg_mem.sv
// Display memory: one write port, two registered read ports.
module bapg_mem
    import bapg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [7:0]        o_rdata_a,
    output logic [7:0]        o_rdata_b
);

    logic [7:0] r_mem [0:MEM_DEPTH-1];
    logic [7:0] r_rdata_a;
    logic [7:0] r_rdata_b;

    // store one byte
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read both ports, hold data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> sv/bapg_shade.sv
// Attribute decode, flash swap, palette lookup and output register.
module bapg_shade
    import bapg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pix_ctl  i_ctl,
    input  logic [7:0] i_pix_byte,
    input  logic [7:0] i_attr_byte,
    input  logic      i_out_ready,
    output logic      o_load_ok,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    logic       r_valid;
    logic       n_valid;
    t_out_item  r_data;
    t_out_item  n_data;
    logic [7:0] pix;
    logic [7:0] attr;
    logic       bit_on;
    logic [2:0] ink;
    logic [2:0] paper;
    logic [3:0] col;

    assign o_load_ok = !r_valid || i_out_ready;

    // mask bytes read beyond the display memory
    always_comb begin
        pix    = i_ctl.pix_ok  ? i_pix_byte  : 8'h00;
        attr   = i_ctl.attr_ok ? i_attr_byte : 8'h00;
        bit_on = pix[3'd7 - i_ctl.bit_pos];
        if (attr[7] && i_ctl.phase) begin
            ink   = attr[5:3];
            paper = attr[2:0];
        end else begin
            ink   = attr[2:0];
            paper = attr[5:3];
        end
        col = {attr[6], bit_on ? ink : paper};
        n_data.color_index = col;
        n_data.argb_color  = PALETTE[col];
    end

    // load a new result when the slot is free or being drained
    always_comb begin
        n_valid = r_valid;
        if (o_load_ok) begin
            n_valid = i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load_ok && i_ctl.valid) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

>>> sv/bitmap_attribute_pixel_generator_unit.sv
// Top level of the bitmap/attribute pixel generator.
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_ready  o_out_data (t_out_item)
//  cfg       input      i_cfg_we                   i_cfg_data (flash period)
//
// One transaction per cycle while o_in_ready is high. A pixel request reads
// bitmap and attribute bytes from the two read ports of the display memory at
// the accepting edge; its result is loaded into the output register once that
// register is free or draining. Writes and frame ticks finish at the accepting
// edge. After reset a clearing pass zeroes the display memory, one byte a cycle,
// with o_in_ready low. A stalled output holds its result; one more pixel may be
// accepted to wait behind it, and then no input is accepted until it drains.
module bitmap_attribute_pixel_generator_unit
    import bapg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] n_clr_addr;
    logic              clearing;

    logic [7:0]        r_flash_period;
    logic [7:0]        r_flash_cnt;
    logic [7:0]        n_flash_cnt;
    logic              r_flash_phase;
    logic              n_flash_phase;
    logic [8:0]        cnt_inc;

    t_pix_ctl          r_s1;
    t_pix_ctl          n_s1;
    logic              load_ok;
    logic              s1_move;

    logic              accept;
    logic              acc_write;
    logic              acc_tick;
    logic              acc_pixel;
    logic              in_window;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] pix_addr;
    logic [ADDR_W-1:0] attr_addr;
    logic              pix_ok;
    logic              attr_ok;
    logic [7:0]        pix_byte;
    logic [7:0]        attr_byte;

    // clearing pass state machine: next state
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == MEM_LAST) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_clr_addr = r_clr_addr;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // clearing pass state machine: outputs
    always_comb begin
        unique case (r_state)
            ST_CLEAR: clearing = 1'b1;
            ST_RUN:   clearing = 1'b0;
            default:  clearing = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    // input handshake and opcode decode
    assign s1_move    = r_s1.valid && load_ok;
    assign o_in_ready = !clearing && (!r_s1.valid || load_ok);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        acc_write = 1'b0;
        acc_tick  = 1'b0;
        acc_pixel = 1'b0;
        unique case (t_opcode'(i_in_data.opcode))
            OP_WRITE: acc_write = accept;
            OP_TICK:  acc_tick  = accept;
            OP_PIXEL: acc_pixel = accept;
            default:  acc_pixel = 1'b0;
        endcase
    end

    // CPU window check and write port mux
    assign in_window = (i_in_data.cpu_address[15:13] == WIN_PAGE)
                    && (i_in_data.cpu_address[12:0] <= MEM_LAST);

    always_comb begin
        if (clearing) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = 8'h00;
        end else begin
            mem_we    = acc_write && in_window;
            mem_waddr = i_in_data.cpu_address[12:0];
            mem_wdata = i_in_data.write_data;
        end
    end

    // interleaved bitmap address and attribute address
    always_comb begin
        pix_addr  = {i_in_data.pixel_y[7:6], i_in_data.pixel_y[2:0],
                     i_in_data.pixel_y[5:3], i_in_data.pixel_x[7:3]};
        attr_addr = ATTR_BASE + {3'b000, i_in_data.pixel_y[7:3],
                                 i_in_data.pixel_x[7:3]};
        pix_ok    = (pix_addr  <= MEM_LAST);
        attr_ok   = (attr_addr <= MEM_LAST);
    end

    // track the pixel request whose bytes are being read
    always_comb begin
        n_s1 = r_s1;
        if (acc_pixel) begin
            n_s1.valid   = 1'b1;
            n_s1.bit_pos = i_in_data.pixel_x[2:0];
            n_s1.pix_ok  = pix_ok;
            n_s1.attr_ok = attr_ok;
            n_s1.phase   = r_flash_phase;
        end else if (s1_move) begin
            n_s1.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    // advance the flash counter, toggle the phase at the period
    always_comb begin
        cnt_inc       = {1'b0, r_flash_cnt} + 9'd1;
        n_flash_cnt   = r_flash_cnt;
        n_flash_phase = r_flash_phase;
        if (acc_tick) begin
            if (cnt_inc >= {1'b0, r_flash_period}) begin
                n_flash_cnt   = 8'd0;
                n_flash_phase = !r_flash_phase;
            end else begin
                n_flash_cnt = cnt_inc[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_cnt    <= 8'd0;
            r_flash_phase  <= 1'b0;
            r_flash_period <= FLASH_PERIOD_RST;
        end else begin
            r_flash_cnt   <= n_flash_cnt;
            r_flash_phase <= n_flash_phase;
            if (i_cfg_we) begin
                r_flash_period <= i_cfg_data;
            end
        end
    end

    bapg_mem u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re      (acc_pixel),
        .i_raddr_a (pix_ok  ? pix_addr  : '0),
        .i_raddr_b (attr_ok ? attr_addr : '0),
        .o_rdata_a (pix_byte),
        .o_rdata_b (attr_byte)
    );

    bapg_shade u_shade (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_s1),
        .i_pix_byte  (pix_byte),
        .i_attr_byte (attr_byte),
        .i_out_ready (i_out_ready),
        .o_load_ok   (load_ok),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // an accepted pixel request is in flight at the next edge
    a_pixel_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_pixel |=> r_s1.valid)
        else $error("pixel request lost after acceptance");

    // a pending pixel survives a stalled output
    a_pixel_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1.valid && o_out_valid && !i_out_ready) |=> r_s1.valid)
        else $error("pending pixel dropped under stall");

    // no CPU write reaches the memory during the clearing pass
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> (!accept && mem_wdata == 8'h00))
        else $error("transaction taken during clearing pass");

endmodule
